FILE: rtl/pgn_text_lexer_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef PGN_TEXT_LEXER_UNIT_ASSERT_SVH
`define PGN_TEXT_LEXER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PTL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// Record kinds, token kinds, error codes and lexer modes for the lexer.
// ----------------------------------------------------------------------------
package ptl_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_SYMBOL, M_BANG, M_QUEST, M_DOLLAR, M_STRING, M_ESCAPE,
    M_LCOMMENT, M_BCOMMENT, M_STAR, M_HALT
  } mode_t;

  localparam logic [1:0] RK_TEXT  = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  localparam logic [3:0] TK_SYMBOL = 4'd7;
  localparam logic [3:0] TK_STRING = 4'd8;
  localparam logic [3:0] TK_INT    = 4'd9;
  localparam logic [3:0] TK_NAG    = 4'd10;
  localparam logic [3:0] TK_RESULT = 4'd11;
  localparam logic [3:0] TK_END    = 4'd12;

  localparam logic [2:0] ERR_EOF_COMMENT = 3'd1;
  localparam logic [2:0] ERR_EOF_STRING  = 3'd2;
  localparam logic [2:0] ERR_NAG_LONG    = 3'd3;
  localparam logic [2:0] ERR_NAG_EMPTY   = 3'd4;
  localparam logic [2:0] ERR_BAD_CHAR    = 3'd5;

  // One result record, before the line and column are attached.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [3:0] tk;
    logic [9:0] nag;
    logic       at_start; // position from start registers, else current
    logic [2:0] err;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_follow(input logic [7:0] c);
    return is_alnum(c) || c == 8'h5f || c == 8'h2b || c == 8'h23 || c == 8'h3d ||
           c == 8'h3a || c == 8'h2d || c == 8'h2f;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Byte of a result pattern at a position, 0 past its end.
  function automatic logic [7:0] pat_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      2'd0: r = (p == 3'd0) ? 8'h31 : (p == 3'd1) ? 8'h2d : (p == 3'd2) ? 8'h30 : 8'h00;
      2'd1: r = (p == 3'd0) ? 8'h30 : (p == 3'd1) ? 8'h2d : (p == 3'd2) ? 8'h31 : 8'h00;
      2'd2: begin
        unique case (p)
          3'd0: r = 8'h31;
          3'd1: r = 8'h2f;
          3'd2: r = 8'h32;
          3'd3: r = 8'h2d;
          3'd4: r = 8'h31;
          3'd5: r = 8'h2f;
          3'd6: r = 8'h32;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ptl_core.sv
// ----------------------------------------------------------------------------
// ptl_core
// Per-byte lexer decision: next state and up to two records from one byte.
// ----------------------------------------------------------------------------
module ptl_core #(
  parameter int NAG_DIGITS = 3
) (
  input  ptl_pkg::mode_t     mode,
  input  logic [7:0]         c,
  input  logic               eof,
  input  logic               col_zero,
  input  logic               all_digits,
  input  logic [2:0]         rmatch,
  input  logic [2:0]         mlen,
  input  logic [9:0]         nag_acc,
  input  logic [2:0]         nag_cnt,
  output ptl_pkg::mode_t     mode_nxt,
  output logic               set_start,
  output logic               all_digits_nxt,
  output logic [2:0]         rmatch_nxt,
  output logic [2:0]         mlen_nxt,
  output logic [9:0]         nag_acc_nxt,
  output logic [2:0]         nag_cnt_nxt,
  output logic [1:0]         n_rec,
  output ptl_pkg::rec_t      rec0,
  output ptl_pkg::rec_t      rec1
);
  import ptl_pkg::*;

  rec_t   b_rec;
  logic   b_has;
  mode_t  b_mode;
  logic   b_start;
  logic   b_sym;
  rec_t   c_rec;
  logic   c_has;
  logic   run_begin;
  logic [2:0] m_step;
  logic [13:0] nag_mul;

  // Match step on the current byte from a given match set and length.
  function automatic logic [2:0] step_match(input logic [2:0] rm, input logic [2:0] ln,
                                            input logic [7:0] ch);
    logic [2:0] r;
    logic [2:0] lim;
    r = rm;
    for (int k = 0; k < 3; k++) begin
      lim = (k == 2) ? 3'd7 : 3'd3;
      if (!(ln < lim && pat_char(2'(k), ln) == ch)) r[k] = 1'b0;
    end
    return r;
  endfunction

  // Handling of a byte that begins a new item.
  always_comb begin
    b_rec   = '0;
    b_has   = 1'b0;
    b_mode  = M_IDLE;
    b_start = 1'b0;
    b_sym   = 1'b0;
    priority if (eof) begin
      b_has = 1'b1; b_rec.kind = RK_TOKEN; b_rec.tk = TK_END; b_mode = M_HALT;
    end else if (is_blank(c)) begin
      b_mode = M_IDLE;
    end else if (c == 8'h3b || (c == 8'h25 && col_zero)) begin
      b_mode = M_LCOMMENT;
    end else if (c == 8'h7b) begin
      b_mode = M_BCOMMENT;
    end else if (c == 8'h2e || c == 8'h5b || c == 8'h5d || c == 8'h28 || c == 8'h29 ||
                 c == 8'h3c || c == 8'h3e) begin
      b_has = 1'b1; b_rec.kind = RK_TOKEN;
      priority case (c)
        8'h2e: b_rec.tk = 4'd0;
        8'h5b: b_rec.tk = 4'd1;
        8'h5d: b_rec.tk = 4'd2;
        8'h28: b_rec.tk = 4'd3;
        8'h29: b_rec.tk = 4'd4;
        8'h3c: b_rec.tk = 4'd5;
        default: b_rec.tk = 4'd6;
      endcase
    end else if (c == 8'h2a) begin
      b_start = 1'b1; b_has = 1'b1; b_rec.kind = RK_TEXT; b_rec.ch = c; b_mode = M_STAR;
    end else if (c == 8'h21) begin
      b_start = 1'b1; b_mode = M_BANG;
    end else if (c == 8'h3f) begin
      b_start = 1'b1; b_mode = M_QUEST;
    end else if (c == 8'h22) begin
      b_start = 1'b1; b_mode = M_STRING;
    end else if (c == 8'h24) begin
      b_start = 1'b1; b_mode = M_DOLLAR;
    end else if (is_alnum(c)) begin
      b_start = 1'b1; b_sym = 1'b1; b_has = 1'b1;
      b_rec.kind = RK_TEXT; b_rec.ch = c; b_mode = M_SYMBOL;
    end else begin
      b_start = 1'b1; b_has = 1'b1; b_rec.kind = RK_ERROR; b_rec.err = ERR_BAD_CHAR;
      b_mode = M_HALT;
    end
  end

  assign m_step  = step_match(rmatch, mlen, c);
  assign nag_mul = 14'(nag_acc) * 14'd10 + 14'(c - 8'h30);

  always_comb begin
    mode_nxt       = mode;
    all_digits_nxt = all_digits;
    rmatch_nxt     = rmatch;
    mlen_nxt       = mlen;
    nag_acc_nxt    = nag_acc;
    nag_cnt_nxt    = nag_cnt;
    c_rec          = '0;
    c_has          = 1'b0;
    run_begin      = 1'b0;
    unique case (mode)
      M_HALT: ;
      M_IDLE: run_begin = 1'b1;
      M_LCOMMENT, M_BCOMMENT: begin
        if (eof) begin
          c_has = 1'b1; c_rec.kind = RK_ERROR; c_rec.err = ERR_EOF_COMMENT; mode_nxt = M_HALT;
        end else if (c == ((mode == M_LCOMMENT) ? 8'h0a : 8'h7d)) begin
          mode_nxt = M_IDLE;
        end
      end
      M_STRING: begin
        priority if (eof) begin
          c_has = 1'b1; c_rec.kind = RK_ERROR; c_rec.err = ERR_EOF_STRING; mode_nxt = M_HALT;
        end else if (c == 8'h22) begin
          c_has = 1'b1; c_rec.kind = RK_TOKEN; c_rec.tk = TK_STRING; c_rec.at_start = 1'b1;
          mode_nxt = M_IDLE;
        end else if (c == 8'h5c) begin
          mode_nxt = M_ESCAPE;
        end else begin
          c_has = 1'b1; c_rec.kind = RK_TEXT; c_rec.ch = c;
        end
      end
      M_ESCAPE: begin
        if (eof) begin
          c_has = 1'b1; c_rec.kind = RK_ERROR; c_rec.err = ERR_EOF_STRING; mode_nxt = M_HALT;
        end else if (c != 8'h22 && c != 8'h5c) begin
          // backslash then the byte
          c_has = 1'b1; c_rec.kind = RK_TEXT; c_rec.ch = 8'h5c; mode_nxt = M_STRING;
        end else begin
          c_has = 1'b1; c_rec.kind = RK_TEXT; c_rec.ch = c; mode_nxt = M_STRING;
        end
      end
      M_BANG, M_QUEST: begin
        c_has = 1'b1; c_rec.kind = RK_TOKEN; c_rec.tk = TK_NAG; c_rec.at_start = 1'b1;
        priority if (!eof && c == 8'h21) begin
          c_rec.nag = (mode == M_BANG) ? 10'd3 : 10'd6; mode_nxt = M_IDLE;
        end else if (!eof && c == 8'h3f) begin
          c_rec.nag = (mode == M_BANG) ? 10'd5 : 10'd4; mode_nxt = M_IDLE;
        end else begin
          c_rec.nag = (mode == M_BANG) ? 10'd1 : 10'd2; run_begin = 1'b1;
        end
      end
      M_STAR: begin
        c_has = 1'b1; c_rec.kind = RK_TOKEN; c_rec.tk = TK_RESULT; c_rec.at_start = 1'b1;
        run_begin = 1'b1;
      end
      M_SYMBOL: begin
        if (!eof && is_follow(c)) begin
          if (!is_digit(c)) all_digits_nxt = 1'b0;
          rmatch_nxt = m_step;
          if (mlen < 3'd7) mlen_nxt = mlen + 3'd1;
          c_has = 1'b1; c_rec.kind = RK_TEXT; c_rec.ch = c;
        end else begin
          c_has = 1'b1; c_rec.kind = RK_TOKEN; c_rec.at_start = 1'b1;
          c_rec.tk = all_digits ? TK_INT : TK_SYMBOL;
          if ((rmatch[0] && mlen == 3'd3) || (rmatch[1] && mlen == 3'd3) ||
              (rmatch[2] && mlen == 3'd7)) c_rec.tk = TK_RESULT;
          run_begin = 1'b1;
        end
      end
      M_DOLLAR: begin
        priority if (!eof && is_digit(c)) begin
          if (nag_cnt >= 3'(NAG_DIGITS)) begin
            c_has = 1'b1; c_rec.kind = RK_ERROR; c_rec.err = ERR_NAG_LONG; mode_nxt = M_HALT;
          end else begin
            nag_acc_nxt = (nag_mul > 14'd1023) ? 10'd1023 : nag_mul[9:0];
            nag_cnt_nxt = nag_cnt + 3'd1;
            c_has = 1'b1; c_rec.kind = RK_TEXT; c_rec.ch = c;
          end
        end else if (nag_cnt == 3'd0) begin
          c_has = 1'b1; c_rec.kind = RK_ERROR; c_rec.err = ERR_NAG_EMPTY; mode_nxt = M_HALT;
        end else begin
          c_has = 1'b1; c_rec.kind = RK_TOKEN; c_rec.tk = TK_NAG; c_rec.nag = nag_acc;
          c_rec.at_start = 1'b1; run_begin = 1'b1;
        end
      end
      default: run_begin = 1'b1;
    endcase

    set_start = 1'b0;
    if (run_begin) begin
      mode_nxt  = b_mode;
      set_start = b_start;
      if (c == 8'h24 && !eof) begin
        nag_acc_nxt = '0; nag_cnt_nxt = '0;
      end
      if (b_sym) begin
        all_digits_nxt = is_digit(c);
        rmatch_nxt     = step_match(3'b111, 3'd0, c);
        mlen_nxt       = 3'd1;
      end
    end

    // Escape of another byte gives two text records.
    rec0  = c_has ? c_rec : b_rec;
    rec1  = b_rec;
    n_rec = 2'(c_has) + 2'(run_begin && b_has);
    if (mode == M_ESCAPE && !eof && c != 8'h22 && c != 8'h5c) begin
      rec1 = '0; rec1.kind = RK_TEXT; rec1.ch = c; n_rec = 2'd2;
    end
  end

endmodule

FILE: rtl/pgn_text_lexer_unit.sv
// ----------------------------------------------------------------------------
// pgn_text_lexer_unit
// Byte-serial lexer for chess game text.
// ----------------------------------------------------------------------------
// Input channel: one byte (in_in_char) or an end-of-file mark
// (in_end_of_file) per transfer, with in_valid / in_stall.
// Result channel: one record per transfer on the out_ ports, with
// out_valid / out_stall; out_last_of_run flags the final record of a byte.
// Each byte is decided combinationally and gives zero, one or two records.
// Those are held in a two-entry result buffer; the first record is shown in
// the cycle after the input transfer.
// Throughput: one byte per cycle while each byte gives at most one record and
// the receiver does not stall; a byte that gives two records fills both
// buffer entries, and input is stalled until the buffer has room for both.
// Reset (rst_n low, synchronous): lexer idle, line 1, column 0, buffer empty.
// When the receiver stalls, the buffered records hold and new bytes are
// stalled as soon as the buffer cannot take a full two-record item.
// After an error or the end token the lexer halts and yields nothing.
// ----------------------------------------------------------------------------
module pgn_text_lexer_unit #(
  parameter int TAB_WIDTH   = 8,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int NAG_DIGITS  = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_in_char,
  input  logic                   in_end_of_file,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_record_kind,
  output logic [7:0]             out_text_char,
  output logic [3:0]             out_token_kind,
  output logic [9:0]             out_nag_value,
  output logic [LINE_BITS-1:0]   out_token_line,
  output logic [COLUMN_BITS-1:0] out_token_column,
  output logic [2:0]             out_error_code,
  output logic                   out_last_of_run
);
  import ptl_pkg::*;

  localparam int TW_BITS = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             ch;
    logic [3:0]             tk;
    logic [9:0]             nag;
    logic [LINE_BITS-1:0]   ln;
    logic [COLUMN_BITS-1:0] col;
    logic [2:0]             err;
    logic                   last;
  } orec_t;

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, sline_r;
  logic [COLUMN_BITS-1:0] col_r, scol_r;
  logic [TW_BITS-1:0]     tph_r;
  logic                   alld_r, alld_nxt;
  logic [2:0]             rm_r, rm_nxt, ml_r, ml_nxt, nc_r, nc_nxt;
  logic [9:0]             na_r, na_nxt;
  logic                   set_start;
  logic [1:0]             n_rec;
  rec_t                   rec0, rec1;
  orec_t                  buf_r [2];
  logic [1:0]             cnt_r;
  logic                   take, pop;
  orec_t                  o0, o1;
  logic [COLUMN_BITS:0]   col_sum;
  logic [COLUMN_BITS-1:0] col_step;

  ptl_core #(.NAG_DIGITS(NAG_DIGITS)) u_core (
    .mode(mode_r), .c(in_in_char), .eof(in_end_of_file), .col_zero(col_r == '0),
    .all_digits(alld_r), .rmatch(rm_r), .mlen(ml_r), .nag_acc(na_r), .nag_cnt(nc_r),
    .mode_nxt(mode_nxt), .set_start(set_start), .all_digits_nxt(alld_nxt),
    .rmatch_nxt(rm_nxt), .mlen_nxt(ml_nxt), .nag_acc_nxt(na_nxt), .nag_cnt_nxt(nc_nxt),
    .n_rec(n_rec), .rec0(rec0), .rec1(rec1)
  );

  // Accept a byte only when the buffer surely has room for two records.
  assign pop      = out_valid && !out_stall;
  assign in_stall = (cnt_r == 2'd2) || (cnt_r == 2'd1 && !pop);
  assign take     = in_valid && !in_stall;

  // Attach position: a token that ends a run uses the start position; errors
  // and a token begun in this same byte use the current position.
  function automatic orec_t mk(input rec_t r, input logic from_start,
                               input logic [LINE_BITS-1:0] sl,
                               input logic [COLUMN_BITS-1:0] sc,
                               input logic [LINE_BITS-1:0] cl,
                               input logic [COLUMN_BITS-1:0] cc);
    orec_t o;
    o      = '0;
    o.kind = r.kind;
    o.ch   = r.ch;
    o.tk   = r.tk;
    o.nag  = r.nag;
    o.err  = r.err;
    if (r.kind != RK_TEXT) begin
      o.ln  = from_start ? sl : cl;
      o.col = from_start ? sc : cc;
    end
    return o;
  endfunction

  always_comb begin
    o0 = mk(rec0, rec0.at_start, sline_r, scol_r, line_r, col_r);
    o1 = mk(rec1, 1'b0, sline_r, scol_r, line_r, col_r);
    o0.last = (n_rec == 2'd1);
    o1.last = 1'b1;
  end

  // Column advance with tab stops and saturation. tph_r tracks the column's
  // position within its tab stop; once the column saturates it no longer
  // matters.
  assign col_step = (in_in_char == 8'h09) ?
                    COLUMN_BITS'(TAB_WIDTH) - COLUMN_BITS'(tph_r) :
                    COLUMN_BITS'(1);
  assign col_sum  = {1'b0, col_r} + {1'b0, col_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= LINE_BITS'(1);
      col_r  <= '0;
      tph_r  <= '0;
      sline_r <= LINE_BITS'(1);
      scol_r <= '0;
      alld_r <= 1'b1;
      rm_r   <= 3'b111;
      ml_r   <= '0;
      na_r   <= '0;
      nc_r   <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      alld_r <= alld_nxt;
      rm_r   <= rm_nxt;
      ml_r   <= ml_nxt;
      na_r   <= na_nxt;
      nc_r   <= nc_nxt;
      if (set_start && mode_r != M_HALT) begin
        sline_r <= line_r;
        scol_r  <= col_r;
      end
      if (!in_end_of_file) begin
        if (in_in_char == 8'h0a) begin
          if (line_r != '1) line_r <= line_r + LINE_BITS'(1);
          col_r <= '0;
          tph_r <= '0;
        end else begin
          col_r <= col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
          if (in_in_char == 8'h09 || tph_r == TW_BITS'(TAB_WIDTH - 1)) begin
            tph_r <= '0;
          end else begin
            tph_r <= tph_r + TW_BITS'(1);
          end
        end
      end
    end
  end

  // Result buffer: entry 0 is the head shown on the ports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r - 2'(pop) + (take ? n_rec : 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf_r[0] <= buf_r[1];
    end
    if (take) begin
      if (n_rec != 2'd0) begin
        if (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop)) begin
          buf_r[0] <= o0;
          buf_r[1] <= o1;
        end else begin
          buf_r[1] <= o0;
        end
      end
    end
  end

  assign out_valid        = cnt_r != 2'd0;
  assign out_record_kind  = buf_r[0].kind;
  assign out_text_char    = buf_r[0].ch;
  assign out_token_kind   = buf_r[0].tk;
  assign out_nag_value    = buf_r[0].nag;
  assign out_token_line   = buf_r[0].ln;
  assign out_token_column = buf_r[0].col;
  assign out_error_code   = buf_r[0].err;
  assign out_last_of_run  = buf_r[0].last;

endmodule

FILE: rtl/ptl_checker.sv
// ----------------------------------------------------------------------------
// ptl_checker
// Port-level checks of the lexer's input and result channels.
// ----------------------------------------------------------------------------
`include "pgn_text_lexer_unit_assert.svh"

module ptl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_record_kind,
  input logic [2:0] out_error_code,
  input logic [7:0] out_text_char,
  input logic       out_last_of_run
);
  import ptl_pkg::*;

  `PTL_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_text_char))
  `PTL_ASSERT_IMP(a_kind, clk, rst_n, out_valid, out_record_kind != 2'd3)
  `PTL_ASSERT_IMP(a_err, clk, rst_n, out_valid && out_record_kind == RK_ERROR, out_error_code != 3'd0 && out_last_of_run)
  `PTL_ASSERT_IMP(a_noerr, clk, rst_n, out_valid && out_record_kind != RK_ERROR, out_error_code == 3'd0)
  `PTL_ASSERT_NEXT(a_empty, clk, rst_n, !out_valid && !in_valid, !in_stall)

endmodule

bind pgn_text_lexer_unit ptl_checker u_ptl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_record_kind(out_record_kind),
  .out_error_code(out_error_code), .out_text_char(out_text_char),
  .out_last_of_run(out_last_of_run)
);
